// ----- src/pmg_pkg.sv -----
package pmg_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = 1 << ADDR_W;
  localparam int FCNT_W   = ADDR_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] VISITED_BIT  = ADDR_W'(16);
  localparam logic [ADDR_W-1:0] FRONTIER_BIT = ADDR_W'(32);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_W = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_E = 2'd3;

  typedef logic [5:0] op_t;

  localparam op_t OP_NOP        = 6'd0;
  localparam op_t OP_START      = 6'd1;
  localparam op_t OP_DRAW_TOTAL = 6'd2;
  localparam op_t OP_SPAWN_DIV  = 6'd3;
  localparam op_t OP_SPAWN_SET  = 6'd4;
  localparam op_t OP_NB_RD      = 6'd5;
  localparam op_t OP_DIR_INC    = 6'd6;
  localparam op_t OP_DIR_CLR    = 6'd7;
  localparam op_t OP_AF_CHK     = 6'd8;
  localparam op_t OP_DRAW_FCNT  = 6'd9;
  localparam op_t OP_PICK_RD1   = 6'd10;
  localparam op_t OP_PICK_RD2   = 6'd11;
  localparam op_t OP_PICK_MV    = 6'd12;
  localparam op_t OP_VIS_CHK    = 6'd13;
  localparam op_t OP_DRAW_CNT   = 6'd14;
  localparam op_t OP_SEL        = 6'd15;
  localparam op_t OP_N_WR       = 6'd16;
  localparam op_t OP_SELF_WR    = 6'd17;
  localparam op_t OP_DRAW_ROWS  = 6'd18;
  localparam op_t OP_DRAW_COLS  = 6'd19;
  localparam op_t OP_DRAW_FOUR  = 6'd20;
  localparam op_t OP_CAP_ER     = 6'd21;
  localparam op_t OP_CAP_SR     = 6'd22;
  localparam op_t OP_CAP_EC     = 6'd23;
  localparam op_t OP_CAP_SC     = 6'd24;
  localparam op_t OP_CAP_P      = 6'd25;
  localparam op_t OP_CAP_Q      = 6'd26;
  localparam op_t OP_ENT_RD     = 6'd27;
  localparam op_t OP_ENT_WR     = 6'd28;
  localparam op_t OP_EXT_RD     = 6'd29;
  localparam op_t OP_EXT_WR     = 6'd30;
  localparam op_t OP_OUT_RD     = 6'd31;
  localparam op_t OP_OUT_LD     = 6'd32;

  typedef struct packed {
    logic div_busy;
    logic nb_ok;
    logic dir_last;
    logic total_one;
    logic fcnt_zero;
    logic cnt_zero;
    logic rows_multi;
    logic cols_multi;
    logic q_ok;
    logic out_free;
    logic out_last;
  } pmg_status_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [3:0] clamp_dim(input logic [3:0] v, input logic [3:0] vmax);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > vmax) begin
      r = vmax;
    end
    return r;
  endfunction

endpackage

// ----- src/prim_maze_generator.sv -----
// Builds one grid_rows by grid_cols maze (each 1 to 8) per seed word by randomized Prim and
// returns one word per cell in row-major order, the final one flagged by out_last; every
// word repeats the entry and exit cell indices. One maze is worked on at a time, and a new
// seed is taken once the previous maze's last word is in the output register. Every random
// draw runs through a serial remainder unit that reduces it to its range. Configuration writes
// are taken in any cycle.
module prim_maze_generator import pmg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_seed,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           out_cell_index,
  output logic [3:0]           out_openings,
  output logic [5:0]           out_entry_cell,
  output logic [5:0]           out_exit_cell,
  output logic                 out_last
);

  op_t         op;
  pmg_status_t status;

  assign cfg_ready = 1'b1;

  pmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  pmg_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .status         (status),
    .in_seed        (in_seed),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_cell_index (out_cell_index),
    .out_openings   (out_openings),
    .out_entry_cell (out_entry_cell),
    .out_exit_cell  (out_exit_cell),
    .out_last       (out_last)
  );

endmodule

// ----- src/pmg_div.sv -----
module pmg_div import pmg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       dividend,
  input  logic [FCNT_W-1:0] divisor,
  output logic              busy,
  output logic [ADDR_W-1:0] rem,
  output logic [ADDR_W-1:0] quo
);

  logic              busy_r;
  logic [3:0]        step_r;
  logic [31:0]       dvd_r;
  logic [FCNT_W-1:0] k_r;
  logic [ADDR_W-1:0] rem_r;
  logic [ADDR_W-1:0] quo_r;

  logic [FCNT_W-1:0] t1, r1, t2, r2;
  logic              q1, q2;

  always_comb begin
    t1 = {rem_r, dvd_r[31]};
    q1 = (t1 >= k_r);
    r1 = q1 ? (t1 - k_r) : t1;
    t2 = {r1[ADDR_W-1:0], dvd_r[30]};
    q2 = (t2 >= k_r);
    r2 = q2 ? (t2 - k_r) : t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= 4'd0;
    end else if (busy_r) begin
      step_r <= step_r + 4'd1;
      if (step_r == 4'd15) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      k_r   <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[29:0], 2'b00};
      rem_r <= r2[ADDR_W-1:0];
      quo_r <= {quo_r[ADDR_W-3:0], q1, q2};
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;
  assign quo  = quo_r;

endmodule

// ----- src/pmg_datapath.sv -----
module pmg_datapath import pmg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  op_t                  op,
  output pmg_status_t          status,
  input  logic [31:0]          in_seed,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]           cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [5:0]           out_cell_index,
  output logic [3:0]           out_openings,
  output logic [5:0]           out_entry_cell,
  output logic [5:0]           out_exit_cell,
  output logic                 out_last
);

  logic [3:0]        grid_rows_r, grid_cols_r;
  logic [3:0]        nr_r, nc_r;
  logic [FCNT_W-1:0] total_r;
  logic [31:0]       rng_r;
  logic [FCNT_W-1:0] fcnt_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [1:0]        dir_r;
  logic [2:0]        cnt_r;
  logic [1:0]        cand_r [4];
  logic [ROW_W-1:0]  er_r, sr_r;
  logic [COL_W-1:0]  ec_r, sc_r;
  logic [1:0]        p_r, q_r;
  logic [ADDR_W-1:0] mov_r;
  logic [ROW_W-1:0]  orow_r;
  logic [COL_W-1:0]  ocol_r;
  logic [ADDR_W-1:0] oidx_r;

  logic [ADDR_W-1:0] cmem [CELLS];
  logic [ADDR_W-1:0] fmem [CELLS];
  logic [CELLS-1:0]  cvld_r;
  logic [ADDR_W-1:0] crd_r;
  logic              crd_vld_r;
  logic [ADDR_W-1:0] frd_r;

  logic       out_valid_r;
  logic [5:0] out_idx_r, out_ent_r, out_ext_r;
  logic [3:0] out_open_r;
  logic       out_last_r;

  logic              div_start, div_busy;
  logic [31:0]       div_dividend;
  logic [FCNT_W-1:0] div_divisor;
  logic [ADDR_W-1:0] div_rem, div_quo;

  logic [3:0]        nr_c, nc_c;
  logic              is_draw;
  logic              nb_ok;
  logic [ROW_W-1:0]  nb_row;
  logic [COL_W-1:0]  nb_col;
  logic [3:0]        own_bit, opp_bit;
  logic [ADDR_W-1:0] cval;
  logic [ROW_W-1:0]  ent_row, ext_row;
  logic [COL_W-1:0]  ent_col, ext_col;
  logic [3:0]        ent_side, ext_side;
  logic [FCNT_W-1:0] ent_prod, ext_prod;
  logic              total_one, q_ok, out_free, last_cell;

  logic              c_we, c_re, f_we, f_re;
  logic [ADDR_W-1:0] c_waddr, c_wdata, c_raddr, f_waddr, f_wdata, f_raddr;

  pmg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  function automatic logic [3:0] border_bit(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                            input logic [3:0] nr, input logic [3:0] nc);
    logic [3:0] b;
    b = 4'd0;
    if ({1'b0, c} == nc - 4'd1) begin
      b = 4'd1;
    end else if ({1'b0, r} == nr - 4'd1) begin
      b = 4'd2;
    end else if (c == '0) begin
      b = 4'd4;
    end else if (r == '0) begin
      b = 4'd8;
    end
    return b;
  endfunction

  function automatic logic [ROW_W-1:0] pos_row(input logic [1:0] p, input logic [ROW_W-1:0] er,
                                               input logic [ROW_W-1:0] sr, input logic [3:0] nr);
    logic [ROW_W-1:0] r;
    unique case (p)
      2'd0: r = '0;
      2'd1: r = er;
      2'd2: r = ROW_W'(nr - 4'd1);
      default: r = sr;
    endcase
    return r;
  endfunction

  function automatic logic [COL_W-1:0] pos_col(input logic [1:0] p, input logic [COL_W-1:0] ec,
                                               input logic [COL_W-1:0] sc, input logic [3:0] nc);
    logic [COL_W-1:0] c;
    unique case (p)
      2'd0: c = ec;
      2'd1: c = COL_W'(nc - 4'd1);
      2'd2: c = sc;
      default: c = '0;
    endcase
    return c;
  endfunction

  assign nr_c = clamp_dim(grid_rows_r, 4'(MAX_ROWS));
  assign nc_c = clamp_dim(grid_cols_r, 4'(MAX_COLS));

  assign is_draw = (op == OP_DRAW_TOTAL) || (op == OP_DRAW_FCNT) || (op == OP_DRAW_CNT) ||
                   (op == OP_DRAW_ROWS) || (op == OP_DRAW_COLS) || (op == OP_DRAW_FOUR);

  always_comb begin
    div_start    = is_draw || (op == OP_SPAWN_DIV);
    div_dividend = xorshift32(rng_r);
    div_divisor  = total_r;
    unique case (op)
      OP_SPAWN_DIV: begin
        div_dividend = {{(32-ADDR_W){1'b0}}, div_rem};
        div_divisor  = FCNT_W'(nc_r);
      end
      OP_DRAW_FCNT: div_divisor = fcnt_r;
      OP_DRAW_CNT:  div_divisor = FCNT_W'(cnt_r);
      OP_DRAW_ROWS: div_divisor = FCNT_W'(nr_r);
      OP_DRAW_COLS: div_divisor = FCNT_W'(nc_r);
      OP_DRAW_FOUR: div_divisor = FCNT_W'(4);
      default:      div_divisor = total_r;
    endcase
  end

  always_comb begin
    nb_ok   = 1'b0;
    nb_row  = cur_row_r;
    nb_col  = cur_col_r;
    own_bit = 4'd1;
    opp_bit = 4'd4;
    unique case (dir_r)
      DIR_N: begin
        nb_ok   = (cur_row_r != '0);
        nb_row  = cur_row_r - ROW_W'(1);
        own_bit = 4'd8;
        opp_bit = 4'd2;
      end
      DIR_W: begin
        nb_ok   = (cur_col_r != '0);
        nb_col  = cur_col_r - COL_W'(1);
        own_bit = 4'd4;
        opp_bit = 4'd1;
      end
      DIR_S: begin
        nb_ok   = (({1'b0, cur_row_r} + 4'd1) < nr_r);
        nb_row  = cur_row_r + ROW_W'(1);
        own_bit = 4'd2;
        opp_bit = 4'd8;
      end
      DIR_E: begin
        nb_ok   = (({1'b0, cur_col_r} + 4'd1) < nc_r);
        nb_col  = cur_col_r + COL_W'(1);
        own_bit = 4'd1;
        opp_bit = 4'd4;
      end
    endcase
  end

  assign cval      = crd_vld_r ? crd_r : '0;
  assign total_one = (total_r == FCNT_W'(1));
  assign ent_row   = pos_row(p_r, er_r, sr_r, nr_r);
  assign ent_col   = pos_col(p_r, ec_r, sc_r, nc_r);
  assign ext_row   = pos_row(q_r, er_r, sr_r, nr_r);
  assign ext_col   = pos_col(q_r, ec_r, sc_r, nc_r);
  assign ent_side  = total_one ? (4'd1 << p_r) : border_bit(ent_row, ent_col, nr_r, nc_r);
  assign ext_side  = total_one ? (4'd1 << q_r) : border_bit(ext_row, ext_col, nr_r, nc_r);
  assign ent_prod  = FCNT_W'(ent_row) * FCNT_W'(nc_r) + FCNT_W'(ent_col);
  assign ext_prod  = FCNT_W'(ext_row) * FCNT_W'(nc_r) + FCNT_W'(ext_col);
  assign q_ok      = total_one ? (q_r != p_r) : ({ext_row, ext_col} != {ent_row, ent_col});
  assign out_free  = !out_valid_r || out_ready;
  assign last_cell = (oidx_r == ADDR_W'(total_r - FCNT_W'(1)));

  always_comb begin
    c_we    = 1'b0;
    c_waddr = {nb_row, nb_col};
    c_wdata = cval | {2'b00, opp_bit};
    unique case (op)
      OP_SPAWN_SET: begin
        c_we    = 1'b1;
        c_waddr = {div_quo[ROW_W-1:0], div_rem[COL_W-1:0]};
        c_wdata = VISITED_BIT;
      end
      OP_AF_CHK: begin
        c_we    = (cval == '0) && !fcnt_r[FCNT_W-1];
        c_wdata = FRONTIER_BIT;
      end
      OP_N_WR: c_we = 1'b1;
      OP_SELF_WR: begin
        c_we    = 1'b1;
        c_waddr = {cur_row_r, cur_col_r};
        c_wdata = VISITED_BIT | {2'b00, own_bit};
      end
      OP_ENT_WR: begin
        c_we    = 1'b1;
        c_waddr = {ent_row, ent_col};
        c_wdata = cval | {2'b00, ent_side};
      end
      OP_EXT_WR: begin
        c_we    = 1'b1;
        c_waddr = {ext_row, ext_col};
        c_wdata = cval | {2'b00, ext_side};
      end
      default: c_we = 1'b0;
    endcase
  end

  always_comb begin
    c_re    = 1'b0;
    c_raddr = {nb_row, nb_col};
    unique case (op)
      OP_NB_RD: c_re = 1'b1;
      OP_ENT_RD: begin
        c_re    = 1'b1;
        c_raddr = {ent_row, ent_col};
      end
      OP_EXT_RD: begin
        c_re    = 1'b1;
        c_raddr = {ext_row, ext_col};
      end
      OP_OUT_RD: begin
        c_re    = 1'b1;
        c_raddr = {orow_r, ocol_r};
      end
      default: c_re = 1'b0;
    endcase
  end

  always_comb begin
    f_we    = 1'b0;
    f_waddr = fcnt_r[ADDR_W-1:0];
    f_wdata = {nb_row, nb_col};
    f_re    = 1'b0;
    f_raddr = div_rem;
    unique case (op)
      OP_AF_CHK: f_we = (cval == '0) && !fcnt_r[FCNT_W-1];
      OP_PICK_RD1: f_re = 1'b1;
      OP_PICK_RD2: begin
        f_re    = 1'b1;
        f_raddr = ADDR_W'(fcnt_r - FCNT_W'(1));
      end
      OP_PICK_MV: begin
        f_we    = 1'b1;
        f_waddr = mov_r;
        f_wdata = frd_r;
      end
      default: f_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      crd_r     <= cmem[c_raddr];
      crd_vld_r <= cvld_r[c_raddr];
    end
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    if (f_re) begin
      frd_r <= fmem[f_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= 4'd4;
      grid_cols_r <= 4'd4;
      rng_r       <= 32'd1;
      fcnt_r      <= '0;
      cvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_ROWS: grid_rows_r <= cfg_data;
          REG_GRID_COLS: grid_cols_r <= cfg_data;
        endcase
      end
      if (op == OP_START) begin
        rng_r  <= (in_seed == 32'd0) ? 32'd1 : in_seed;
        fcnt_r <= '0;
        cvld_r <= '0;
      end else begin
        if (is_draw) begin
          rng_r <= xorshift32(rng_r);
        end
        if (c_we) begin
          cvld_r[c_waddr] <= 1'b1;
        end
        if (op == OP_AF_CHK && f_we) begin
          fcnt_r <= fcnt_r + FCNT_W'(1);
        end else if (op == OP_PICK_MV) begin
          fcnt_r <= fcnt_r - FCNT_W'(1);
        end
      end
      if (op == OP_OUT_LD) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_START: begin
        nr_r    <= nr_c;
        nc_r    <= nc_c;
        total_r <= FCNT_W'(nr_c) * FCNT_W'(nc_c);
        er_r    <= '0;
        sr_r    <= '0;
        ec_r    <= '0;
        sc_r    <= '0;
        orow_r  <= '0;
        ocol_r  <= '0;
        oidx_r  <= '0;
      end
      OP_SPAWN_SET: begin
        cur_row_r <= div_quo[ROW_W-1:0];
        cur_col_r <= div_rem[COL_W-1:0];
        dir_r     <= DIR_N;
      end
      OP_DIR_INC, OP_AF_CHK: dir_r <= dir_r + 2'd1;
      OP_DIR_CLR, OP_SELF_WR: dir_r <= DIR_N;
      OP_VIS_CHK: begin
        if (cval[4]) begin
          cand_r[cnt_r[1:0]] <= dir_r;
          cnt_r <= cnt_r + 3'd1;
        end
        dir_r <= dir_r + 2'd1;
      end
      OP_PICK_RD1: mov_r <= div_rem;
      OP_PICK_RD2: begin
        cur_row_r <= frd_r[ADDR_W-1:COL_W];
        cur_col_r <= frd_r[COL_W-1:0];
      end
      OP_PICK_MV: begin
        dir_r <= DIR_N;
        cnt_r <= 3'd0;
      end
      OP_SEL:    dir_r <= cand_r[div_rem[1:0]];
      OP_CAP_ER: er_r <= div_rem[ROW_W-1:0];
      OP_CAP_SR: sr_r <= div_rem[ROW_W-1:0];
      OP_CAP_EC: ec_r <= div_rem[COL_W-1:0];
      OP_CAP_SC: sc_r <= div_rem[COL_W-1:0];
      OP_CAP_P:  p_r <= div_rem[1:0];
      OP_CAP_Q:  q_r <= div_rem[1:0];
      OP_OUT_LD: begin
        out_idx_r  <= oidx_r;
        out_open_r <= cval[3:0];
        out_ent_r  <= ent_prod[ADDR_W-1:0];
        out_ext_r  <= ext_prod[ADDR_W-1:0];
        out_last_r <= last_cell;
        oidx_r     <= oidx_r + ADDR_W'(1);
        if (({1'b0, ocol_r} + 4'd1) == nc_r) begin
          ocol_r <= '0;
          orow_r <= orow_r + ROW_W'(1);
        end else begin
          ocol_r <= ocol_r + COL_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    status.div_busy   = div_busy;
    status.nb_ok      = nb_ok;
    status.dir_last   = (dir_r == DIR_E);
    status.total_one  = total_one;
    status.fcnt_zero  = (fcnt_r == '0);
    status.cnt_zero   = (cnt_r == 3'd0);
    status.rows_multi = (nr_r > 4'd1);
    status.cols_multi = (nc_r > 4'd1);
    status.q_ok       = q_ok;
    status.out_free   = out_free;
    status.out_last   = last_cell;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_index = out_idx_r;
  assign out_openings   = out_open_r;
  assign out_entry_cell = out_ent_r;
  assign out_exit_cell  = out_ext_r;
  assign out_last       = out_last_r;

endmodule

// ----- src/pmg_ctrl.sv -----
module pmg_ctrl import pmg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pmg_status_t status,
  output op_t         op
);

  localparam logic [5:0] ST_IDLE     = 6'd0;
  localparam logic [5:0] ST_SPAWN    = 6'd1;
  localparam logic [5:0] ST_SPAWN_W  = 6'd2;
  localparam logic [5:0] ST_SPAWN_DW = 6'd3;
  localparam logic [5:0] ST_AF_RD    = 6'd4;
  localparam logic [5:0] ST_AF_CHK   = 6'd5;
  localparam logic [5:0] ST_LOOP     = 6'd6;
  localparam logic [5:0] ST_PICK_W   = 6'd7;
  localparam logic [5:0] ST_PICK_R2  = 6'd8;
  localparam logic [5:0] ST_PICK_MV  = 6'd9;
  localparam logic [5:0] ST_OP_RD    = 6'd10;
  localparam logic [5:0] ST_OP_CHK   = 6'd11;
  localparam logic [5:0] ST_OP_END   = 6'd12;
  localparam logic [5:0] ST_OP_W     = 6'd13;
  localparam logic [5:0] ST_N_RD     = 6'd14;
  localparam logic [5:0] ST_N_WR     = 6'd15;
  localparam logic [5:0] ST_SELF     = 6'd16;
  localparam logic [5:0] ST_ER       = 6'd17;
  localparam logic [5:0] ST_ER_W     = 6'd18;
  localparam logic [5:0] ST_SR       = 6'd19;
  localparam logic [5:0] ST_SR_W     = 6'd20;
  localparam logic [5:0] ST_EC       = 6'd21;
  localparam logic [5:0] ST_EC_W     = 6'd22;
  localparam logic [5:0] ST_SC       = 6'd23;
  localparam logic [5:0] ST_SC_W     = 6'd24;
  localparam logic [5:0] ST_P        = 6'd25;
  localparam logic [5:0] ST_P_W      = 6'd26;
  localparam logic [5:0] ST_Q        = 6'd27;
  localparam logic [5:0] ST_Q_W      = 6'd28;
  localparam logic [5:0] ST_Q_CHK    = 6'd29;
  localparam logic [5:0] ST_ENT_RD   = 6'd30;
  localparam logic [5:0] ST_ENT_WR   = 6'd31;
  localparam logic [5:0] ST_EXT_RD   = 6'd32;
  localparam logic [5:0] ST_EXT_WR   = 6'd33;
  localparam logic [5:0] ST_OUT_RD   = 6'd34;
  localparam logic [5:0] ST_OUT_LD   = 6'd35;

  logic [5:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_START;
          state_nxt = ST_SPAWN;
        end
      end
      ST_SPAWN: begin
        op        = OP_DRAW_TOTAL;
        state_nxt = ST_SPAWN_W;
      end
      ST_SPAWN_W: begin
        if (!status.div_busy) begin
          if (status.total_one) begin
            state_nxt = ST_ER;
          end else begin
            op        = OP_SPAWN_DIV;
            state_nxt = ST_SPAWN_DW;
          end
        end
      end
      ST_SPAWN_DW: begin
        if (!status.div_busy) begin
          op        = OP_SPAWN_SET;
          state_nxt = ST_AF_RD;
        end
      end
      ST_AF_RD: begin
        if (status.nb_ok) begin
          op        = OP_NB_RD;
          state_nxt = ST_AF_CHK;
        end else if (status.dir_last) begin
          state_nxt = ST_LOOP;
        end else begin
          op = OP_DIR_INC;
        end
      end
      ST_AF_CHK: begin
        op        = OP_AF_CHK;
        state_nxt = status.dir_last ? ST_LOOP : ST_AF_RD;
      end
      ST_LOOP: begin
        if (status.fcnt_zero) begin
          state_nxt = ST_ER;
        end else begin
          op        = OP_DRAW_FCNT;
          state_nxt = ST_PICK_W;
        end
      end
      ST_PICK_W: begin
        if (!status.div_busy) begin
          op        = OP_PICK_RD1;
          state_nxt = ST_PICK_R2;
        end
      end
      ST_PICK_R2: begin
        op        = OP_PICK_RD2;
        state_nxt = ST_PICK_MV;
      end
      ST_PICK_MV: begin
        op        = OP_PICK_MV;
        state_nxt = ST_OP_RD;
      end
      ST_OP_RD: begin
        if (status.nb_ok) begin
          op        = OP_NB_RD;
          state_nxt = ST_OP_CHK;
        end else if (status.dir_last) begin
          state_nxt = ST_OP_END;
        end else begin
          op = OP_DIR_INC;
        end
      end
      ST_OP_CHK: begin
        op        = OP_VIS_CHK;
        state_nxt = status.dir_last ? ST_OP_END : ST_OP_RD;
      end
      ST_OP_END: begin
        if (status.cnt_zero) begin
          op        = OP_DIR_CLR;
          state_nxt = ST_AF_RD;
        end else begin
          op        = OP_DRAW_CNT;
          state_nxt = ST_OP_W;
        end
      end
      ST_OP_W: begin
        if (!status.div_busy) begin
          op        = OP_SEL;
          state_nxt = ST_N_RD;
        end
      end
      ST_N_RD: begin
        op        = OP_NB_RD;
        state_nxt = ST_N_WR;
      end
      ST_N_WR: begin
        op        = OP_N_WR;
        state_nxt = ST_SELF;
      end
      ST_SELF: begin
        op        = OP_SELF_WR;
        state_nxt = ST_AF_RD;
      end
      ST_ER: begin
        if (status.rows_multi) begin
          op        = OP_DRAW_ROWS;
          state_nxt = ST_ER_W;
        end else begin
          state_nxt = ST_EC;
        end
      end
      ST_ER_W: begin
        if (!status.div_busy) begin
          op        = OP_CAP_ER;
          state_nxt = ST_SR;
        end
      end
      ST_SR: begin
        op        = OP_DRAW_ROWS;
        state_nxt = ST_SR_W;
      end
      ST_SR_W: begin
        if (!status.div_busy) begin
          op        = OP_CAP_SR;
          state_nxt = ST_EC;
        end
      end
      ST_EC: begin
        if (status.cols_multi) begin
          op        = OP_DRAW_COLS;
          state_nxt = ST_EC_W;
        end else begin
          state_nxt = ST_P;
        end
      end
      ST_EC_W: begin
        if (!status.div_busy) begin
          op        = OP_CAP_EC;
          state_nxt = ST_SC;
        end
      end
      ST_SC: begin
        op        = OP_DRAW_COLS;
        state_nxt = ST_SC_W;
      end
      ST_SC_W: begin
        if (!status.div_busy) begin
          op        = OP_CAP_SC;
          state_nxt = ST_P;
        end
      end
      ST_P: begin
        op        = OP_DRAW_FOUR;
        state_nxt = ST_P_W;
      end
      ST_P_W: begin
        if (!status.div_busy) begin
          op        = OP_CAP_P;
          state_nxt = ST_Q;
        end
      end
      ST_Q: begin
        op        = OP_DRAW_FOUR;
        state_nxt = ST_Q_W;
      end
      ST_Q_W: begin
        if (!status.div_busy) begin
          op        = OP_CAP_Q;
          state_nxt = ST_Q_CHK;
        end
      end
      ST_Q_CHK: begin
        state_nxt = status.q_ok ? ST_ENT_RD : ST_Q;
      end
      ST_ENT_RD: begin
        op        = OP_ENT_RD;
        state_nxt = ST_ENT_WR;
      end
      ST_ENT_WR: begin
        op        = OP_ENT_WR;
        state_nxt = ST_EXT_RD;
      end
      ST_EXT_RD: begin
        op        = OP_EXT_RD;
        state_nxt = ST_EXT_WR;
      end
      ST_EXT_WR: begin
        op        = OP_EXT_WR;
        state_nxt = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        op        = OP_OUT_RD;
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (status.out_free) begin
          op        = OP_OUT_LD;
          state_nxt = status.out_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule
